@@ rtl/ihex_pkg.sv @@
// shared types, constants and helpers for the intel hex record decoder
// no dependencies; imported by ihex_front, ihex_back and the top level
package ihex_pkg;

    // line length, colon and newline included, that gives a line-too-long error
    localparam int MAX_LINE = 256;
    localparam int LINE_W   = $clog2(MAX_LINE + 1);

    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    // result kinds
    localparam logic [2:0] KIND_WRITE    = 3'd0;
    localparam logic [2:0] KIND_EOF      = 3'd1;
    localparam logic [2:0] KIND_NO_COLON = 3'd2;
    localparam logic [2:0] KIND_BAD_TYPE = 3'd3;
    localparam logic [2:0] KIND_TOO_LONG = 3'd4;
    localparam logic [2:0] KIND_TRUNC    = 3'd5;

    // record types that are accepted
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;

    typedef logic [LINE_W-1:0] line_len_t;

    // one character after classification
    typedef struct packed {
        logic       is_newline;
        logic       is_colon;
        logic [3:0] nibble;
    } ihex_class_t;

    // one result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic [16:0] extent;
    } ihex_result_t;

    // hex digit value, anything else counts as zero
    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                d = c - 8'h30;
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                d = c - 8'h57;
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                d = c - 8'h37;
            end
            return d[3:0];
        end
    endfunction

endpackage

@@ rtl/ihex_front.sv @@
// front end: accepts characters, classifies them and queues the classes
// depends on ihex_pkg
module ihex_front
    import ihex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [7:0]  ch,
    output logic        full,
    output logic        cls_valid,
    output ihex_class_t cls,
    input  logic        cls_take
);

    ihex_class_t q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    ihex_class_t incoming;
    logic        do_push;
    logic        do_pop;

    assign full      = (count_reg == 2'd2);
    assign cls_valid = (count_reg != 2'd0);
    assign cls       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cls_take && cls_valid;

    always_comb
    begin
        incoming.is_newline = (ch == CHAR_NEWLINE);
        incoming.is_colon   = (ch == CHAR_COLON);
        incoming.nibble     = digit_value(ch);
    end

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

@@ rtl/ihex_back.sv @@
// back end: record parser state machine and two-entry result queue
// depends on ihex_pkg
module ihex_back
    import ihex_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cls_valid,
    input  ihex_class_t  cls,
    output logic         cls_take,
    input  logic         pop,
    output logic         empty,
    output ihex_result_t res
);

    typedef enum logic [2:0] {
        PH_COLON,
        PH_COUNT,
        PH_ADDR_HI,
        PH_ADDR_LO,
        PH_TYPE,
        PH_DATA,
        PH_CKSUM,
        PH_SKIP
    } phase_t;

    phase_t       phase_reg, phase_next;
    line_len_t    line_len_reg, line_len_next;
    logic [3:0]   high_nib_reg, high_nib_next;
    logic         pending_reg, pending_next;
    logic [7:0]   total_reg, total_next;
    logic [15:0]  rec_addr_reg, rec_addr_next;
    logic         rec_eof_reg, rec_eof_next;
    logic [7:0]   index_reg, index_next;
    logic [16:0]  high_end_reg, high_end_next;
    logic         halted_reg, halted_next;

    ihex_result_t q_reg [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   count_reg, count_next;

    ihex_result_t new_res;
    logic         res_push;
    logic         res_full;
    logic         do_pop;
    line_len_t    line_inc;
    logic [7:0]   byte_val;
    logic [7:0]   index_inc;
    logic [16:0]  end_addr;

    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign res      = q_reg[rd_ptr_reg];
    assign do_pop   = pop && !empty;
    assign cls_take = cls_valid && !res_full;

    assign line_inc  = line_len_reg + line_len_t'(1);
    assign byte_val  = {high_nib_reg, cls.nibble};
    assign index_inc = index_reg + 8'd1;
    assign end_addr  = {1'b0, rec_addr_reg} + {9'd0, total_reg};

    always_comb
    begin
        phase_next    = phase_reg;
        line_len_next = line_len_reg;
        high_nib_next = high_nib_reg;
        pending_next  = pending_reg;
        total_next    = total_reg;
        rec_addr_next = rec_addr_reg;
        rec_eof_next  = rec_eof_reg;
        index_next    = index_reg;
        high_end_next = high_end_reg;
        halted_next   = halted_reg;
        res_push      = 1'b0;
        new_res       = '0;

        if (cls_take && !halted_reg)
        begin
            line_len_next = line_inc;
            if (line_inc >= line_len_t'(MAX_LINE))
            begin
                halted_next  = 1'b1;
                res_push     = 1'b1;
                new_res.kind = KIND_TOO_LONG;
            end
            else if (cls.is_newline)
            begin
                if (phase_reg == PH_COLON)
                begin
                    halted_next  = 1'b1;
                    res_push     = 1'b1;
                    new_res.kind = KIND_NO_COLON;
                end
                else if (phase_reg != PH_SKIP)
                begin
                    halted_next  = 1'b1;
                    res_push     = 1'b1;
                    new_res.kind = KIND_TRUNC;
                end
                else
                begin
                    line_len_next = '0;
                    pending_next  = 1'b0;
                    phase_next    = PH_COLON;
                    if (rec_eof_reg)
                    begin
                        halted_next    = 1'b1;
                        res_push       = 1'b1;
                        new_res.kind   = KIND_EOF;
                        new_res.extent = high_end_reg;
                    end
                end
            end
            else if (phase_reg == PH_COLON)
            begin
                if (!cls.is_colon)
                begin
                    halted_next  = 1'b1;
                    res_push     = 1'b1;
                    new_res.kind = KIND_NO_COLON;
                end
                else
                begin
                    pending_next = 1'b0;
                    phase_next   = PH_COUNT;
                end
            end
            else if (phase_reg == PH_SKIP)
            begin
                // trailing characters up to the newline
            end
            else if (!pending_reg)
            begin
                high_nib_next = cls.nibble;
                pending_next  = 1'b1;
            end
            else
            begin
                pending_next = 1'b0;
                unique case (phase_reg)
                    PH_COUNT:
                    begin
                        total_next = byte_val;
                        phase_next = PH_ADDR_HI;
                    end
                    PH_ADDR_HI:
                    begin
                        rec_addr_next = {byte_val, 8'h00};
                        phase_next    = PH_ADDR_LO;
                    end
                    PH_ADDR_LO:
                    begin
                        rec_addr_next = {rec_addr_reg[15:8], byte_val};
                        phase_next    = PH_TYPE;
                    end
                    PH_TYPE:
                    begin
                        rec_eof_next = (byte_val == REC_EOF);
                        if (byte_val != REC_DATA && byte_val != REC_EOF)
                        begin
                            halted_next  = 1'b1;
                            res_push     = 1'b1;
                            new_res.kind = KIND_BAD_TYPE;
                        end
                        else
                        begin
                            index_next = 8'd0;
                            phase_next = (total_reg != 8'd0) ? PH_DATA : PH_CKSUM;
                        end
                    end
                    PH_DATA:
                    begin
                        index_next = index_inc;
                        if (index_inc >= total_reg)
                        begin
                            phase_next = PH_CKSUM;
                        end
                        if (!rec_eof_reg)
                        begin
                            res_push              = 1'b1;
                            new_res.kind          = KIND_WRITE;
                            new_res.write_address = rec_addr_reg + {8'd0, index_reg};
                            new_res.write_data    = byte_val;
                        end
                    end
                    default:
                    begin
                        // checksum byte, read but not checked
                        if (!rec_eof_reg && end_addr > high_end_reg)
                        begin
                            high_end_next = end_addr;
                        end
                        phase_next = PH_SKIP;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (res_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !res_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_COLON;
            line_len_reg <= '0;
            high_nib_reg <= 4'd0;
            pending_reg  <= 1'b0;
            total_reg    <= 8'd0;
            rec_addr_reg <= 16'd0;
            rec_eof_reg  <= 1'b0;
            index_reg    <= 8'd0;
            high_end_reg <= 17'd0;
            halted_reg   <= 1'b0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            count_reg    <= 2'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            line_len_reg <= line_len_next;
            high_nib_reg <= high_nib_next;
            pending_reg  <= pending_next;
            total_reg    <= total_next;
            rec_addr_reg <= rec_addr_next;
            rec_eof_reg  <= rec_eof_next;
            index_reg    <= index_next;
            high_end_reg <= high_end_next;
            halted_reg   <= halted_next;
            wr_ptr_reg   <= res_push ? ~wr_ptr_reg : wr_ptr_reg;
            rd_ptr_reg   <= do_pop ? ~rd_ptr_reg : rd_ptr_reg;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            q_reg[wr_ptr_reg] <= new_res;
        end
    end

endmodule

@@ rtl/intel_hex_record_decoder.sv @@
// top level of the intel hex record decoder: front end, back end, port wiring
// depends on ihex_pkg, ihex_front and ihex_back
//
// Streaming Intel HEX decoder, one ASCII character per transfer on the input
// queue (push/full), results on the output queue (empty/pop). It sustains one
// character per clock: the front end classifies each character (newline,
// colon, hex digit value) into a two-entry queue, and the back end parser
// takes one class per clock whenever its two-entry result queue has room;
// each class is registered in the front end queue and each result in the
// result queue before it is on the output ports.
// Each type 0 data byte gives a write result (kind 0) with its address and
// data; the newline of a type 1 record gives end of file (kind 1) with the
// highest end address written. A missing colon, a record type other than 0
// or 1, a line of MAX_LINE characters or more, or a newline before the
// checksum is complete gives a single error result; after an error or end of
// file every character is taken and dropped until reset. The checksum is not
// verified. Fields that do not belong to a result kind read as zero.
module intel_hex_record_decoder
    import ihex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // character input queue
    input  logic        push,
    input  logic [7:0]  ch,
    output logic        full,
    // result output queue
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  kind,
    output logic [15:0] write_address,
    output logic [7:0]  write_data,
    output logic [16:0] extent
);

    ihex_class_t  cls;
    logic         cls_valid;
    logic         cls_take;
    ihex_result_t res;

    // classification and input queue
    ihex_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .ch        (ch),
        .full      (full),
        .cls_valid (cls_valid),
        .cls       (cls),
        .cls_take  (cls_take)
    );

    // record parser and result queue
    ihex_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (cls_valid),
        .cls       (cls),
        .cls_take  (cls_take),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    assign kind          = res.kind;
    assign write_address = res.write_address;
    assign write_data    = res.write_data;
    assign extent        = res.extent;

    // only defined kinds leave the block
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> kind <= KIND_TRUNC)
        else $error("undefined result kind");

    // address and data are zero outside write results
    a_write_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind != KIND_WRITE) |-> (write_address == 16'd0 && write_data == 8'd0))
        else $error("write fields set on a non-write result");

    // extent is zero outside end of file results
    a_extent_field: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind != KIND_EOF) |-> extent == 17'd0)
        else $error("extent set on a non-eof result");

endmodule
